// ----- rtl/gcb_pkg.sv -----
// Package: grapheme break classes, cluster modes and the pair-join rules.
`timescale 1ns / 1ps

package gcb_pkg;

   localparam int unsigned ClassWidth = 4;
   localparam int unsigned ModeWidth  = 3;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 8;

   typedef enum logic [ClassWidth-1:0] {
      CLS_OTHER   = 4'd0,
      CLS_CR      = 4'd1,
      CLS_LF      = 4'd2,
      CLS_CONTROL = 4'd3,
      CLS_EXTEND  = 4'd4,
      CLS_ZWJ     = 4'd5,
      CLS_SM      = 4'd6,
      CLS_PREPEND = 4'd7,
      CLS_RI      = 4'd8,
      CLS_L       = 4'd9,
      CLS_V       = 4'd10,
      CLS_T       = 4'd11,
      CLS_LV      = 4'd12,
      CLS_LVT     = 4'd13
   } class_type;

   typedef enum logic [ModeWidth-1:0] {
      MODE_IDLE  = 3'd0,
      MODE_GEN   = 3'd1,
      MODE_EBASE = 3'd2,
      MODE_EZWJ  = 3'd3,
      MODE_TRAIL = 3'd4,
      MODE_FLAG1 = 3'd5
   } mode_type;

   typedef struct packed {
      logic starts_cluster;
      logic error;
      logic final_res;
   } result_type;

   function automatic logic is_trailer(class_type c);
      return (c inside {CLS_EXTEND, CLS_ZWJ, CLS_SM});
   endfunction

   function automatic logic is_ctl(class_type c);
      return (c inside {CLS_CR, CLS_LF, CLS_CONTROL});
   endfunction

   // Pair rule inside a general cluster: high when cur joins prev.
   function automatic logic pair_joins(class_type p, class_type c);
      logic j;
      j = 1'b0;
      if (is_ctl(p) || is_ctl(c)) begin
         j = 1'b0;
      end else if (p == CLS_L && (c inside {CLS_L, CLS_V, CLS_LV, CLS_LVT})) begin
         j = 1'b1;
      end else if ((p inside {CLS_LV, CLS_V}) && (c inside {CLS_V, CLS_T})) begin
         j = 1'b1;
      end else if ((p inside {CLS_LVT, CLS_T}) && c == CLS_T) begin
         j = 1'b1;
      end else if (is_trailer(c) || p == CLS_PREPEND) begin
         j = 1'b1;
      end
      return j;
   endfunction

   // Mode opened by a code point that starts a cluster.
   function automatic mode_type open_mode(class_type c, logic pict);
      mode_type m;
      if (pict) begin
         m = MODE_EBASE;
      end else if (c == CLS_RI) begin
         m = MODE_FLAG1;
      end else begin
         m = MODE_GEN;
      end
      return m;
   endfunction

endpackage

// ----- rtl/grapheme_cluster_boundary_top.sv -----
// Top level: grapheme cluster boundary detector with a streaming in/out port pair.
`timescale 1ns / 1ps

// Grapheme cluster boundary detector. Feed one decoded code point per transfer
// with its grapheme break class and extended-pictographic flag; every input
// transfer yields exactly one result transfer, in order, telling whether a new
// grapheme cluster starts at that code point. The block sustains one code point
// per clock while req_tready is high: the cluster mode and the previous class
// are updated by a single level of decision logic at the input transfer, and the
// result is registered. A result register plus a one-entry skid stage
// sit on the result side, so a new code point is taken even while a result
// waits; req_tready drops only when both entries are full. A code point flagged
// invalid (req_tuser) comes back with error set and starts_cluster set, and the
// next code point starts a fresh cluster; so does the one after an item marked
// with req_tlast. Class codes 14 and 15 are treated as other. No configuration.
module grapheme_cluster_boundary_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [3:0] break_class, [4] pictographic, [7:5] zero
   input  logic       req_tuser,  // [0] invalid
   input  logic       req_tlast,  // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [0] starts_cluster, [7:1] zero
   output logic       rsp_tuser,  // [0] error
   output logic       rsp_tlast   // final_res
);

   // cluster state
   gcb_pkg::mode_type   mode_ff, mode_in;
   gcb_pkg::class_type  prev_class_ff;

   // result register and skid stage
   gcb_pkg::result_type out_ff, skid_ff, res_in;
   logic                out_valid_ff, skid_valid_ff;

   gcb_pkg::class_type  cls;
   logic                pict, bad, eot;
   logic                push, pop;

   assign pict = req_tdata[4];
   assign bad  = req_tuser;
   assign eot  = req_tlast;

   // fold unused class codes onto other
   always_comb begin
      if (req_tdata[3:0] > gcb_pkg::CLS_LVT) begin
         cls = gcb_pkg::CLS_OTHER;
      end else begin
         cls = gcb_pkg::class_type'(req_tdata[3:0]);
      end
   end

   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   // boundary decision and next cluster mode
   always_comb begin
      logic             join_ok;
      gcb_pkg::mode_type nxt;
      join_ok = 1'b0;
      nxt     = mode_ff;
      case (mode_ff)
         gcb_pkg::MODE_GEN: begin
            if (prev_class_ff == gcb_pkg::CLS_CR && cls == gcb_pkg::CLS_LF) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_IDLE;   // CR LF closes the cluster
            end else if (gcb_pkg::pair_joins(prev_class_ff, cls)) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_GEN;
            end
         end
         gcb_pkg::MODE_EBASE: begin
            if (cls == gcb_pkg::CLS_EXTEND) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_EBASE;
            end else if (cls == gcb_pkg::CLS_ZWJ) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_EZWJ;
            end else if (cls == gcb_pkg::CLS_SM) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_TRAIL;
            end
         end
         gcb_pkg::MODE_EZWJ: begin
            if (pict) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_EBASE;
            end else if (gcb_pkg::is_trailer(cls)) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_TRAIL;
            end
         end
         gcb_pkg::MODE_FLAG1: begin
            if (cls == gcb_pkg::CLS_RI || gcb_pkg::is_trailer(cls)) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_TRAIL;
            end
         end
         gcb_pkg::MODE_TRAIL: begin
            if (gcb_pkg::is_trailer(cls)) begin
               join_ok = 1'b1;
               nxt     = gcb_pkg::MODE_TRAIL;
            end
         end
         default: begin
            join_ok = 1'b0;
         end
      endcase

      if (bad) begin
         mode_in = gcb_pkg::MODE_IDLE;
         res_in.starts_cluster = 1'b1;
      end else begin
         if (join_ok) begin
            mode_in = nxt;
         end else begin
            mode_in = gcb_pkg::open_mode(cls, pict);
         end
         if (eot) begin
            mode_in = gcb_pkg::MODE_IDLE;
         end
         res_in.starts_cluster = !join_ok;
      end
      res_in.error     = bad;
      res_in.final_res = eot;
   end

   // advance cluster state on every input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= gcb_pkg::MODE_IDLE;
         prev_class_ff <= gcb_pkg::CLS_OTHER;
      end else if (push) begin
         mode_ff       <= mode_in;
         prev_class_ff <= cls;
      end
   end

   // result register and skid stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // input is held off; drain skid into the result register
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= res_in;
         end else begin
            out_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(gcb_pkg::RspDataWidth-1){1'b0}}, out_ff.starts_cluster};
   assign rsp_tuser  = out_ff.error;
   assign rsp_tlast  = out_ff.final_res;

endmodule

// ----- rtl/gcb_checker.sv -----
// Checker: port-level assertions for the grapheme cluster boundary detector, and its bind.
`timescale 1ns / 1ps

module gcb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                     && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // an errored code point always opens a new cluster
   a_err_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[0])
      else $error("error result without cluster start");

   // input is held off only while a result waits on the output
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input held off with no result offered");

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind grapheme_cluster_boundary_top gcb_checker u_gcb_checker (.*);
